@@ rtl/npa3d_pkg.sv @@
// ----------------------------------------------------------------------------
// npa3d_pkg
// Shared widths, register indexes and controller/datapath bundles for the
// 3D nearest-point search.
// ----------------------------------------------------------------------------
package npa3d_pkg;

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int MAX_POINTS = 16384;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int DIST_W     = SQ_W / 2;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS + 1);
    localparam int REM_W      = DIST_W + 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       square;
        logic [1:0] axis;
        logic       compare;
        logic       root_step;
        logic       push;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic root_done;
        logic out_free;
    } t_status;

endpackage

@@ rtl/npa3d_ctrl.sv @@
// ----------------------------------------------------------------------------
// npa3d_ctrl
// Sequencer: capture a point, square the three differences on one shared
// multiplier, run the best-distance compare, then the root on a last point.
// ----------------------------------------------------------------------------
module npa3d_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  npa3d_pkg::t_status i_status,
    output npa3d_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SQUARE  = 5'b00010,
        ST_COMPARE = 5'b00100,
        ST_ROOT    = 5'b01000,
        ST_PUSH    = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state         = r_state;
        n_axis          = r_axis;
        o_cmd           = '0;
        o_cmd.axis      = r_axis;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_axis        = npa3d_pkg::AXIS_X;
                    n_state       = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                if (r_axis == npa3d_pkg::AXIS_Z) begin
                    n_state = ST_COMPARE;
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            ST_COMPARE: begin
                o_cmd.compare = 1'b1;
                n_state = i_status.last ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // hold the result until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= npa3d_pkg::AXIS_X;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

endmodule

@@ rtl/npa3d_dp.sv @@
// ----------------------------------------------------------------------------
// npa3d_dp
// Datapath: query registers, differences, shared squarer and accumulator,
// running minimum, bit-serial square root and the output register.
// ----------------------------------------------------------------------------
module npa3d_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [npa3d_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic signed [npa3d_pkg::COORD_W-1:0] i_cfg_data,
    input  logic signed [npa3d_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [npa3d_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [npa3d_pkg::COORD_W-1:0] i_point_z,
    input  logic                                 i_last_point,
    input  npa3d_pkg::t_cmd                      i_cmd,
    output npa3d_pkg::t_status                   o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [npa3d_pkg::IDX_W-1:0]          o_closest_index,
    output logic [npa3d_pkg::DIST_W-1:0]         o_closest_distance
);

    localparam int DW = npa3d_pkg::DIFF_W;
    localparam int SW = npa3d_pkg::SQ_W;
    localparam int IW = npa3d_pkg::IDX_W;
    localparam int RW = npa3d_pkg::REM_W;
    localparam int OW = npa3d_pkg::DIST_W;
    localparam logic [IW-1:0] CNT_MAX = IW'(npa3d_pkg::MAX_POINTS - 1);

    logic signed [npa3d_pkg::COORD_W-1:0] r_qx, r_qy, r_qz;
    logic signed [DW-1:0] r_dx, r_dy, r_dz;
    logic                 r_last;
    logic [SW-1:0]        r_acc;
    logic [SW-1:0]        r_best;
    logic [IW-1:0]        r_pos, r_cnt;
    logic                 r_have;
    logic [SW-1:0]        r_rv;
    logic [IW-1:0]        r_ridx;
    logic [RW-1:0]        r_rem;
    logic [OW-1:0]        r_root;
    logic [npa3d_pkg::STEP_W-1:0] r_step;
    logic                 r_out_valid;
    logic [IW-1:0]        r_out_idx;
    logic [OW-1:0]        r_out_dist;

    logic signed [DW-1:0] diff_sel;
    logic signed [SW-1:0] sq;
    logic                 win;
    logic [SW-1:0]        n_best;
    logic [IW-1:0]        n_pos;
    logic [RW-1:0]        rem_sh, trial;
    logic                 take;

    always_comb begin
        case (i_cmd.axis)
            npa3d_pkg::AXIS_X: diff_sel = r_dx;
            npa3d_pkg::AXIS_Y: diff_sel = r_dy;
            npa3d_pkg::AXIS_Z: diff_sel = r_dz;
            default:           diff_sel = r_dz;
        endcase
    end

    assign sq = SW'(diff_sel) * SW'(diff_sel);

    assign win    = !r_have || (r_acc < r_best);
    assign n_best = win ? r_acc : r_best;
    assign n_pos  = win ? r_cnt : r_pos;

    assign rem_sh = {r_rem[RW-3:0], r_rv[SW-1 -: 2]};
    assign trial  = RW'({r_root, 2'b01});
    assign take   = (rem_sh >= trial);

    assign o_status.last      = r_last;
    assign o_status.root_done = (r_step == npa3d_pkg::STEP_W'(npa3d_pkg::ROOT_STEPS - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_closest_index    = r_out_idx;
    assign o_closest_distance = r_out_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                npa3d_pkg::REG_QUERY_X: r_qx <= i_cfg_data;
                npa3d_pkg::REG_QUERY_Y: r_qy <= i_cfg_data;
                npa3d_pkg::REG_QUERY_Z: r_qz <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // point capture and squared distance accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dx   <= DW'(i_point_x) - DW'(r_qx);
            r_dy   <= DW'(i_point_y) - DW'(r_qy);
            r_dz   <= DW'(i_point_z) - DW'(r_qz);
            r_last <= i_last_point;
        end
        if (i_cmd.square) begin
            r_acc <= (i_cmd.axis == npa3d_pkg::AXIS_X) ? SW'(sq) : r_acc + SW'(sq);
        end
    end

    // running minimum over the set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
            r_pos  <= '0;
            r_cnt  <= '0;
            r_have <= 1'b0;
        end else if (i_cmd.compare) begin
            if (r_last) begin
                r_best <= '0;
                r_pos  <= '0;
                r_cnt  <= '0;
                r_have <= 1'b0;
            end else begin
                r_best <= n_best;
                r_pos  <= n_pos;
                r_have <= 1'b1;
                if (r_cnt < CNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // restoring square root, one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_rv   <= n_best;
            r_ridx <= n_pos;
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end else if (i_cmd.root_step) begin
            r_rv   <= {r_rv[SW-3:0], 2'b00};
            r_rem  <= take ? rem_sh - trial : rem_sh;
            r_root <= {r_root[OW-2:0], take};
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_idx  <= r_ridx;
            r_out_dist <= r_root;
        end
    end

endmodule

@@ rtl/nearest_point_argmin_3d_core.sv @@
// ----------------------------------------------------------------------------
// nearest_point_argmin_3d_core
// Brute-force 3D nearest-point search against a programmable query point.
// ----------------------------------------------------------------------------
// Per point: accept, three squaring steps on the one shared multiplier,
//   compare; the next point is taken once the block is back in idle.
// A last point then adds 17 square-root iterations and a push, which
//   waits until the output register is free.
// Reset: synchronous active low; clears query registers, set state and the
//   output valid. No clearing pass.
// ----------------------------------------------------------------------------
module nearest_point_argmin_3d_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [npa3d_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic signed [npa3d_pkg::COORD_W-1:0] i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [npa3d_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [npa3d_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [npa3d_pkg::COORD_W-1:0] i_point_z,
    input  logic                                 i_last_point,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [npa3d_pkg::IDX_W-1:0]          o_closest_index,
    output logic [npa3d_pkg::DIST_W-1:0]         o_closest_distance
);

    npa3d_pkg::t_cmd    cmd;
    npa3d_pkg::t_status status;

    npa3d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    npa3d_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .i_point_z          (i_point_z),
        .i_last_point       (i_last_point),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_closest_index    (o_closest_index),
        .o_closest_distance (o_closest_distance)
    );

endmodule

@@ verif/nearest_point_argmin_3d_core_tb.sv @@
// ----------------------------------------------------------------------------
// nearest_point_argmin_3d_core_tb
// Streams signed Q8.8 point sets into the 3D nearest-point search; checks
// every closest index and root distance vs. a local predictor or typed row.
// A short table of directed points (extremes, ties, query change inside a
// set, unused register index) comes first, then random sets with random
// stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module nearest_point_argmin_3d_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 30;
    localparam int END_CYCLES      = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 4000;
    localparam int RANDOM_POINTS   = 420;
    localparam int DIR_ROWS        = 23;

    // Index past the query registers; a write there must be dropped.
    localparam logic [npa3d_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [npa3d_pkg::COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [npa3d_pkg::IDX_W-1:0]  pos;
        logic [npa3d_pkg::DIST_W-1:0] root_dist;
    } t_nearest;

    typedef enum logic {ROW_POINT, ROW_QUERY} t_row_kind;

    typedef struct packed {
        t_row_kind                    kind;
        t_coord                       x;
        t_coord                       y;
        t_coord                       z;
        logic                         last;   // on a query row: also poke the unused index
        logic                         typed;
        logic [npa3d_pkg::IDX_W-1:0]  pos;
        logic [npa3d_pkg::DIST_W-1:0] root_dist;
    } t_dir_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [npa3d_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    t_coord                            i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    t_coord                            i_point_x;
    t_coord                            i_point_y;
    t_coord                            i_point_z;
    logic                              i_last_point;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic [npa3d_pkg::IDX_W-1:0]       o_closest_index;
    logic [npa3d_pkg::DIST_W-1:0]      o_closest_distance;

    nearest_point_argmin_3d_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .i_point_z          (i_point_z),
        .i_last_point       (i_last_point),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_closest_index    (o_closest_index),
        .o_closest_distance (o_closest_distance)
    );

    // Predictor state: query point and the running search of the open set.
    t_coord                        qry_x;
    t_coord                        qry_y;
    t_coord                        qry_z;
    logic [npa3d_pkg::SQ_W-1:0]    run_best_sq;
    logic [npa3d_pkg::IDX_W-1:0]   run_best_pos;
    logic [npa3d_pkg::IDX_W-1:0]   run_count;
    bit                            run_started;

    t_nearest          nearest_q[$];
    int                mismatches;
    int                quiet_cycles;
    bit                no_idle;
    bit                hold_off_req;

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [npa3d_pkg::SQ_W-1:0] dist_sq(input t_coord x, input t_coord y,
                                                           input t_coord z);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(x) - longint'(qry_x);
        dy = longint'(y) - longint'(qry_y);
        dz = longint'(z) - longint'(qry_z);
        return npa3d_pkg::SQ_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic logic [npa3d_pkg::DIST_W-1:0] floor_root(
        input logic [npa3d_pkg::SQ_W-1:0] v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem  = 64'(v);
        root = 64'd0;
        bitv = 64'h1 << 32;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return npa3d_pkg::DIST_W'(root);
    endfunction

    task automatic predict_point(input t_coord x, input t_coord y, input t_coord z,
                                 input logic last, output bit hit, output t_nearest res);
        logic [npa3d_pkg::SQ_W-1:0] dsq;
        dsq = dist_sq(x, y, z);
        if (!run_started || dsq < run_best_sq) begin
            run_best_sq  = dsq;
            run_best_pos = run_count;
        end
        run_started = 1'b1;
        if (int'(run_count) < npa3d_pkg::MAX_POINTS - 1)
            run_count = run_count + 1'b1;
        hit           = last;
        res.pos       = run_best_pos;
        res.root_dist = floor_root(run_best_sq);
        if (last) begin
            run_best_sq  = '0;
            run_best_pos = '0;
            run_count    = '0;
            run_started  = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold the request until accepted, then record what it should produce.
    task automatic send_point(input t_coord x, input t_coord y, input t_coord z,
                              input logic last, input bit typed, input t_nearest typed_res);
        int       gap;
        bit       hit;
        t_nearest res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_point_x    <= x;
        i_point_y    <= y;
        i_point_z    <= z;
        i_last_point <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_point(x, y, z, last, hit, res);
        if (hit)
            nearest_q.push_back(typed ? typed_res : res);
    endtask

    // Drop the request and let the block go quiet before touching the query.
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (nearest_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [npa3d_pkg::CFG_IDX_W-1:0] idx, input t_coord data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            npa3d_pkg::REG_QUERY_X: qry_x = data;
            npa3d_pkg::REG_QUERY_Y: qry_y = data;
            npa3d_pkg::REG_QUERY_Z: qry_z = data;
            default: ;
        endcase
    endtask

    task automatic program_query(input t_coord x, input t_coord y, input t_coord z,
                                 input bit poke_unused);
        cfg_write(npa3d_pkg::REG_QUERY_X, x);
        cfg_write(npa3d_pkg::REG_QUERY_Y, y);
        cfg_write(npa3d_pkg::REG_QUERY_Z, z);
        if (poke_unused)
            cfg_write(REG_UNUSED, t_coord'($urandom()));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_coord pick_extreme();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    function automatic t_coord rand_coord(input t_coord base);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return t_coord'($urandom());
        if (r < 8)
            return base + t_coord'(int'($urandom_range(0, 64)) - 32);
        return pick_extreme();
    endfunction

    function automatic t_coord rand_query_coord();
        if ($urandom_range(0, 2) == 0)
            return pick_extreme();
        return t_coord'($urandom());
    endfunction

    task automatic random_query();
        t_coord e;
        case ($urandom_range(0, 4))
            0: program_query(16'sh8000, 16'sh8000, 16'sh8000, 1'($urandom_range(0, 1)));
            1: program_query(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'($urandom_range(0, 1)));
            2: begin
                e = pick_extreme();
                program_query(e, -e, e, 1'($urandom_range(0, 1)));
            end
            default: program_query(rand_query_coord(), rand_query_coord(),
                                   rand_query_coord(), 1'($urandom_range(0, 1)));
        endcase
    endtask

    initial begin : stimulus
        t_dir_row dir_rows [DIR_ROWS];
        t_nearest none;
        t_coord   px;
        t_coord   py;
        t_coord   pz;
        int       sent;
        int       set_no;
        int       set_len;
        int       r;
        bit       saved_no_idle;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= npa3d_pkg::REG_QUERY_X;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_point_x    <= '0;
        i_point_y    <= '0;
        i_point_z    <= '0;
        i_last_point <= 1'b0;
        qry_x        = '0;
        qry_y        = '0;
        qry_z        = '0;
        run_best_sq  = '0;
        run_best_pos = '0;
        run_count    = '0;
        run_started  = 1'b0;
        mismatches   = 0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        none         = '0;

        dir_rows = '{
            // reset query at the origin
            '{ROW_POINT,      0,      0,      0, 1, 1, 0,      0},
            '{ROW_POINT,    256,      0,      0, 1, 1, 0,    256},
            // equal distances: the first one stays
            '{ROW_POINT,      0,      0,      5, 0, 0, 0,      0},
            '{ROW_POINT,      3,      4,      0, 0, 0, 0,      0},
            '{ROW_POINT,      4,      3,      0, 1, 1, 0,      5},
            '{ROW_POINT, -32768, -32768, -32768, 1, 0, 0,      0},
            '{ROW_POINT,  32767,  32767,  32767, 1, 0, 0,      0},
            '{ROW_POINT,   1000,      0,      0, 0, 0, 0,      0},
            '{ROW_POINT,    500,      0,      0, 0, 0, 0,      0},
            '{ROW_POINT,   -200,      0,      0, 0, 0, 0,      0},
            '{ROW_POINT,    200,      0,      0, 1, 1, 2,    200},
            // corner query; the unused index must not disturb it
            '{ROW_QUERY, -32768, -32768, -32768, 1, 0, 0,      0},
            '{ROW_POINT,  32767,  32767,  32767, 1, 1, 0, 113509},
            '{ROW_POINT, -32768, -32768, -32768, 1, 1, 0,      0},
            '{ROW_QUERY,  32767, -32768,  32767, 0, 0, 0,      0},
            '{ROW_POINT,  32000, -32000,  32000, 0, 0, 0,      0},
            '{ROW_POINT,      0,      0,      0, 0, 0, 0,      0},
            // query moves inside the open set
            '{ROW_QUERY,      0,      0,      0, 0, 0, 0,      0},
            '{ROW_POINT,      0,      0,      0, 1, 1, 2,      0},
            '{ROW_POINT,     -1,     -1,     -1, 0, 0, 0,      0},
            '{ROW_POINT,      1,      1,      1, 1, 1, 0,      1},
            '{ROW_POINT,  21845, -21846,  32767, 1, 0, 0,      0},
            '{ROW_POINT, -21846,  21845, -32768, 1, 0, 0,      0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_QUERY) begin
                settle_idle();
                program_query(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                              dir_rows[i].last);
            end else begin
                send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].last,
                           dir_rows[i].typed, '{pos: dir_rows[i].pos,
                                                root_dist: dir_rows[i].root_dist});
            end
        end

        sent   = 0;
        set_no = 0;
        px     = '0;
        py     = '0;
        pz     = '0;
        while (sent < RANDOM_POINTS) begin
            set_no++;
            if (set_no % 6 == 1) begin
                settle_idle();
                random_query();
            end
            if (set_no % 10 == 3)
                no_idle = ($urandom_range(0, 3) == 0);
            if (set_no == 20) begin
                // Stall the output long enough that the block backs up.
                hold_off_req  = 1'b1;
                saved_no_idle = no_idle;
                no_idle       = 1'b1;
                repeat (12) begin
                    send_point(rand_coord(qry_x), rand_coord(qry_y), rand_coord(qry_z),
                               1'b1, 1'b0, none);
                    sent++;
                end
                no_idle = saved_no_idle;
            end
            r = $urandom_range(0, 99);
            set_len = (r < 70) ? $urandom_range(1, 6) :
                      (r < 95) ? $urandom_range(7, 20) : $urandom_range(21, 40);
            for (int k = 0; k < set_len; k++) begin
                // Repeat the previous point now and then to force a tie.
                if (k == 0 || $urandom_range(0, 99) >= 15) begin
                    px = rand_coord(qry_x);
                    py = rand_coord(qry_y);
                    pz = rand_coord(qry_z);
                end
                send_point(px, py, pz, k == set_len - 1, 1'b0, none);
                sent++;
            end
        end

        // Leave a set open: no result may come from it.
        repeat (3)
            send_point(rand_coord(qry_x), rand_coord(qry_y), rand_coord(qry_z),
                       1'b0, 1'b0, none);
        i_in_valid <= 1'b0;

        while (nearest_q.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (nearest_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, nearest_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("nearest_point_argmin_3d_core_tb OK");
        end else begin
            $display("nearest_point_argmin_3d_core_tb NOT OK");
        end
        $finish;
    end

    initial begin : result_sink
        int n;
        int r;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_out_ready <= 1'b1;
                    n = $urandom_range(1, 6);
                end else if (r < 93) begin
                    i_out_ready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    i_out_ready <= 1'b0;
                    n = $urandom_range(10, 60);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_nearest want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (nearest_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual index %0d dist %0d",
                         $realtime, o_closest_index, o_closest_distance);
                mismatches++;
            end else begin
                want = nearest_q.pop_front();
                if (o_closest_index !== want.pos) begin
                    $display("%0t: closest_index expected %0d actual %0d",
                             $realtime, want.pos, o_closest_index);
                    mismatches++;
                end
                if (o_closest_distance !== want.root_dist) begin
                    $display("%0t: closest_distance expected %0d actual %0d",
                             $realtime, want.root_dist, o_closest_distance);
                    mismatches++;
                end
            end
        end
    end

    // End the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("nearest_point_argmin_3d_core_tb NOT OK");
            $finish;
        end
    end

endmodule
